// File: design/alpha_key_pixel_combiner_unit_defines.svh
// ----------------------------------------------------------------------------
// Alpha key pixel combiner assertion macros
// Shared assertion shorthands for the combiner block.
// ----------------------------------------------------------------------------
`ifndef ALPHA_KEY_PIXEL_COMBINER_UNIT_DEFINES_SVH
`define ALPHA_KEY_PIXEL_COMBINER_UNIT_DEFINES_SVH

// same-cycle implication
`define AKPC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AKPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/akpc_pkg.sv
// ----------------------------------------------------------------------------
// Alpha key pixel combiner package
// Format codes, register map and pixel constants.
// ----------------------------------------------------------------------------
package akpc_pkg;

   typedef enum logic [1:0] {
      DF_INDEXED8  = 2'd0,
      DF_RGB555    = 2'd1,
      DF_RGB565    = 2'd2,
      DF_XRGB8888  = 2'd3
   } dest_format_type;

   typedef enum logic [1:0] {
      SF_INDEXED8  = 2'd0,
      SF_RGB555    = 2'd1,
      SF_ARGB8888  = 2'd2
   } source_format_type;

   localparam int unsigned ADDR_W = 4;

   localparam logic [1:0] REG_DEST_FORMAT   = 2'd0;
   localparam logic [1:0] REG_SOURCE_FORMAT = 2'd1;
   localparam logic [1:0] REG_COLOR_KEY     = 2'd2;
   localparam logic [1:0] REG_GLOBAL_ALPHA  = 2'd3;

   localparam logic [7:0] COLOR_KEY_RST    = 8'd0;
   localparam logic [8:0] GLOBAL_ALPHA_RST = 9'd256;
   localparam logic [8:0] GLOBAL_ALPHA_MAX = 9'd256;

   localparam logic [7:0]  MASK5       = 8'hF8;
   localparam logic [7:0]  MASK6       = 8'hFC;
   localparam logic [15:0] MASK_RG555  = 16'hFFC0;
   localparam logic [15:0] MASK_B5     = 16'h001F;
   localparam logic [7:0]  ALPHA_OPQ   = 8'd255;
   localparam logic [7:0]  ALPHA_CLR   = 8'd0;

endpackage

// File: design/akpc_req_if.sv
// ----------------------------------------------------------------------------
// Alpha key pixel combiner request channel
// Valid/ready channel carrying a source and a destination pixel.
// ----------------------------------------------------------------------------
interface akpc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_pixel;
   logic [31:0] dest_pixel;

   modport source (output valid, source_pixel, dest_pixel, input ready);
   modport sink   (input valid, source_pixel, dest_pixel, output ready);
endinterface

// File: design/akpc_rsp_if.sv
// ----------------------------------------------------------------------------
// Alpha key pixel combiner response channel
// Valid/ready channel carrying the pixel to write back and its flags.
// ----------------------------------------------------------------------------
interface akpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] new_pixel;
   logic        write_enable;
   logic        unsupported;

   modport source (output valid, new_pixel, write_enable, unsupported, input ready);
   modport sink   (input valid, new_pixel, write_enable, unsupported, output ready);
endinterface

// File: design/alpha_key_pixel_combiner_unit.sv
// ----------------------------------------------------------------------------
// Alpha key pixel combiner unit
// Per-pixel color key, 555 conversion and alpha blend, three-stage pipeline.
// ----------------------------------------------------------------------------
// Channel   Dir  Protocol     Payload
// req       in   valid/ready  source_pixel, dest_pixel
// rsp       out  valid/ready  new_pixel, write_enable, unsupported
// csr       in   APB          dest_format, source_format, color_key, global_alpha
//
// One beat per cycle while the response side is ready. Stage 1 decodes,
// keys, converts 555, scales alpha and unpacks, stage 2 holds the channel
// products, stage 3 rounds, packs and selects. Each stage stalls only when
// full and blocked downstream, so bubbles are squeezed out. Reset is
// synchronous, clears the valid bits and resets the config registers.
// ----------------------------------------------------------------------------
`include "alpha_key_pixel_combiner_unit_defines.svh"

module alpha_key_pixel_combiner_unit
   import akpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   akpc_req_if.sink            req_chan,
   akpc_rsp_if.source          rsp_chan,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // configuration registers
   dest_format_type   dest_format_ff;
   source_format_type source_format_ff;
   logic [7:0]        color_key_ff;
   logic [8:0]        global_alpha_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_format_ff   <= DF_XRGB8888;
         source_format_ff <= SF_ARGB8888;
         color_key_ff     <= COLOR_KEY_RST;
         global_alpha_ff  <= GLOBAL_ALPHA_RST;
      end else if (csr_wr) begin
         case (paddr[ADDR_W-1:2])
            REG_DEST_FORMAT:   dest_format_ff   <= dest_format_type'(pwdata[1:0]);
            REG_SOURCE_FORMAT: source_format_ff <= source_format_type'(pwdata[1:0]);
            REG_COLOR_KEY:     color_key_ff     <= pwdata[7:0];
            REG_GLOBAL_ALPHA:  global_alpha_ff  <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_W-1:2])
         REG_DEST_FORMAT:   prdata = {30'd0, dest_format_ff};
         REG_SOURCE_FORMAT: prdata = {30'd0, source_format_ff};
         REG_COLOR_KEY:     prdata = {24'd0, color_key_ff};
         REG_GLOBAL_ALPHA:  prdata = {23'd0, global_alpha_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // stage enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_en, s2_en, s3_en;

   assign s3_en = !s3_valid_ff || rsp_chan.ready;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   // ---------------- stage 1: decode, alpha scale, unpack
   logic [31:0]      s1_dv_in, s1_np_fix_in, s1_np_copy_in;
   logic             s1_we_fix_in, s1_bad_in, s1_argb_in;
   logic [7:0]       s1_alpha_in;
   logic [2:0][7:0]  s1_dch_in, s1_sch_in;
   logic [8:0]       ga_sat;
   logic [16:0]      ga_prod;
   logic [31:0]      sp;
   logic [15:0]      s16;

   logic [31:0]      s1_dv_ff, s1_np_fix_ff, s1_np_copy_ff;
   logic             s1_we_fix_ff, s1_bad_ff, s1_argb_ff;
   logic [7:0]       s1_alpha_ff;
   logic [2:0][7:0]  s1_dch_ff, s1_sch_ff;
   dest_format_type  s1_df_ff;

   always_comb begin
      sp  = req_chan.source_pixel;
      s16 = sp[15:0];
      case (dest_format_ff)
         DF_INDEXED8:          s1_dv_in = {24'd0, req_chan.dest_pixel[7:0]};
         DF_RGB555, DF_RGB565: s1_dv_in = {16'd0, req_chan.dest_pixel[15:0]};
         default:              s1_dv_in = req_chan.dest_pixel;
      endcase

      s1_bad_in = ((dest_format_ff == DF_INDEXED8) != (source_format_ff == SF_INDEXED8))
               || (source_format_ff != SF_INDEXED8 && source_format_ff != SF_RGB555
                   && source_format_ff != SF_ARGB8888);
      s1_argb_in = !s1_bad_in && (source_format_ff == SF_ARGB8888);

      s1_np_fix_in = s1_dv_in;
      s1_we_fix_in = 1'b0;
      if (!s1_bad_in && source_format_ff == SF_INDEXED8) begin
         if (sp[7:0] != color_key_ff) begin
            s1_np_fix_in = {24'd0, sp[7:0]};
            s1_we_fix_in = 1'b1;
         end
      end else if (!s1_bad_in && source_format_ff == SF_RGB555 && s16[15]) begin
         s1_we_fix_in = 1'b1;
         case (dest_format_ff)
            DF_RGB555: s1_np_fix_in = {16'd0, s16};
            DF_RGB565: s1_np_fix_in = {16'd0, ({s16[14:0], 1'b0} & MASK_RG555)
                                              | (s16 & MASK_B5)};
            default:   s1_np_fix_in = {s1_dv_in[31:24], s16[14:10], 3'd0,
                                       s16[9:5], 3'd0, s16[4:0], 3'd0};
         endcase
      end

      ga_sat  = (global_alpha_ff > GLOBAL_ALPHA_MAX) ? GLOBAL_ALPHA_MAX : global_alpha_ff;
      ga_prod = {8'd0, ga_sat} * {9'd0, sp[31:24]};
      s1_alpha_in = (dest_format_ff == DF_XRGB8888) ? ga_prod[15:8] : sp[31:24];

      s1_sch_in = {sp[23:16], sp[15:8], sp[7:0]};
      case (dest_format_ff)
         DF_RGB555: begin
            s1_dch_in = {s1_dv_in[14:10], 3'd0, s1_dv_in[9:5], 3'd0, s1_dv_in[4:0], 3'd0};
            s1_np_copy_in = {17'd0, sp[23:19], sp[15:11], sp[7:3]};
         end
         DF_RGB565: begin
            s1_dch_in = {s1_dv_in[15:11], 3'd0, s1_dv_in[10:5], 2'd0, s1_dv_in[4:0], 3'd0};
            s1_np_copy_in = {16'd0, sp[23:19], sp[15:10], sp[7:3]};
         end
         default: begin
            s1_dch_in = s1_dv_in[23:0];
            s1_np_copy_in = sp;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && req_chan.valid) begin
         s1_dv_ff      <= s1_dv_in;
         s1_np_fix_ff  <= s1_np_fix_in;
         s1_np_copy_ff <= s1_np_copy_in;
         s1_we_fix_ff  <= s1_we_fix_in;
         s1_bad_ff     <= s1_bad_in;
         s1_argb_ff    <= s1_argb_in;
         s1_alpha_ff   <= s1_alpha_in;
         s1_dch_ff     <= s1_dch_in;
         s1_sch_ff     <= s1_sch_in;
         s1_df_ff      <= dest_format_ff;
      end
   end

   // ---------------- stage 2: channel differences and products
   logic [2:0][15:0] s2_prod_in;
   logic [2:0]       s2_ge_in;
   logic [2:0][7:0]  diff;

   logic [31:0]      s2_dv_ff, s2_np_fix_ff, s2_np_copy_ff;
   logic             s2_we_fix_ff, s2_bad_ff, s2_argb_ff, s2_opq_ff, s2_clr_ff;
   logic [2:0][15:0] s2_prod_ff;
   logic [2:0]       s2_ge_ff;
   logic [2:0][7:0]  s2_dch_ff;
   dest_format_type  s2_df_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_ge_in[c]   = s1_sch_ff[c] >= s1_dch_ff[c];
         diff[c]       = s2_ge_in[c] ? s1_sch_ff[c] - s1_dch_ff[c]
                                     : s1_dch_ff[c] - s1_sch_ff[c];
         s2_prod_in[c] = {8'd0, s1_alpha_ff} * {8'd0, diff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_dv_ff      <= s1_dv_ff;
         s2_np_fix_ff  <= s1_np_fix_ff;
         s2_np_copy_ff <= s1_np_copy_ff;
         s2_we_fix_ff  <= s1_we_fix_ff;
         s2_bad_ff     <= s1_bad_ff;
         s2_argb_ff    <= s1_argb_ff;
         s2_opq_ff     <= s1_alpha_ff == ALPHA_OPQ;
         s2_clr_ff     <= s1_alpha_ff == ALPHA_CLR;
         s2_prod_ff    <= s2_prod_in;
         s2_ge_ff      <= s2_ge_in;
         s2_dch_ff     <= s1_dch_ff;
         s2_df_ff      <= s1_df_ff;
      end
   end

   // ---------------- stage 3: round, pack, select
   logic [2:0][7:0]  mix;
   logic [16:0]      rnd;
   logic [31:0]      blend;
   logic [31:0]      s3_np_in;
   logic             s3_we_in;

   logic [31:0]      s3_np_ff;
   logic             s3_we_ff, s3_bad_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rnd    = {1'b0, s2_prod_ff[c]} + 17'd255;
         mix[c] = s2_ge_ff[c] ? s2_dch_ff[c] + s2_prod_ff[c][15:8]
                              : s2_dch_ff[c] - rnd[15:8];
      end
      case (s2_df_ff)
         DF_RGB555: blend = {17'd0, mix[2][7:3], mix[1][7:3], mix[0][7:3]};
         DF_RGB565: blend = {16'd0, mix[2][7:3], mix[1][7:2], mix[0][7:3]};
         default:   blend = {s2_dv_ff[31:24], mix[2], mix[1], mix[0]};
      endcase

      if (!s2_argb_ff) begin
         s3_np_in = s2_np_fix_ff;
         s3_we_in = s2_we_fix_ff;
      end else if (s2_clr_ff) begin
         s3_np_in = s2_dv_ff;
         s3_we_in = 1'b0;
      end else if (s2_opq_ff) begin
         s3_np_in = s2_np_copy_ff;
         s3_we_in = 1'b1;
      end else begin
         s3_np_in = blend;
         s3_we_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en && s2_valid_ff) begin
         s3_np_ff  <= s3_np_in;
         s3_we_ff  <= s3_we_in;
         s3_bad_ff <= s2_bad_ff;
      end
   end

   assign rsp_chan.valid        = s3_valid_ff;
   assign rsp_chan.new_pixel    = s3_np_ff;
   assign rsp_chan.write_enable = s3_we_ff;
   assign rsp_chan.unsupported  = s3_bad_ff;

   // ---------------- checks
   logic [2:0] occ;
   assign occ = {s1_valid_ff, s2_valid_ff, s3_valid_ff};

   `AKPC_ASSERT_NOW(a_bad_no_write, clock, reset, rsp_chan.valid && rsp_chan.unsupported, !rsp_chan.write_enable, "unsupported beat marked for write")
   `AKPC_ASSERT_NEXT(a_occ_grows, clock, reset, req_chan.valid && req_chan.ready && !(rsp_chan.valid && rsp_chan.ready), $countones(occ) == $countones($past(occ)) + 1, "accepted beat lost in pipeline")
   `AKPC_ASSERT_NEXT(a_empty_quiet, clock, reset, occ == 3'd0, !rsp_chan.valid, "response beat from empty pipeline")

endmodule

// File: bench/akpc_writeback_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel combiner writeback checker
// Watches the request, response and register ports of the combiner. Keeps a
// copy of the config registers. For every request beat it computes the pixel
// to write back, and it compares each response beat field by field with the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module akpc_writeback_checker
   import akpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   akpc_req_if               req_mon,
   akpc_rsp_if               rsp_mon,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output int                fail_count,
   output int                pending_count
);

   typedef struct packed {
      logic [31:0] new_pixel;
      logic        write_enable;
      logic        unsupported;
   } pixel_writeback_type;

   logic [1:0] dest_fmt;
   logic [1:0] src_fmt;
   logic [7:0] key;
   logic [8:0] glob_alpha;

   pixel_writeback_type expected_writes[$];

   // d + floor(a*(s-d)/256)
   function automatic logic [7:0] blend_channel(logic [7:0] d, logic [7:0] s, logic [7:0] a);
      logic [16:0] prod;
      if (s >= d) begin
         prod = a * (s - d);
         return d + prod[15:8];
      end
      prod = a * (d - s) + 17'd255;
      return d - prod[15:8];
   endfunction

   function automatic pixel_writeback_type combine_pixel(logic [31:0] src, logic [31:0] dst);
      pixel_writeback_type res;
      logic [31:0] dmask;
      logic [31:0] dv;
      logic [31:0] np;
      logic [15:0] s16;
      logic [7:0]  a;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  dr;
      logic [7:0]  dg;
      logic [7:0]  db;
      logic [8:0]  ga_sat;
      logic [16:0] scaled;
      logic        we;
      logic        bad;
      case (dest_fmt)
         DF_INDEXED8: dmask = 32'h0000_00FF;
         DF_XRGB8888: dmask = 32'hFFFF_FFFF;
         default:     dmask = 32'h0000_FFFF;
      endcase
      dv  = dst & dmask;
      np  = dv;
      we  = 1'b0;
      bad = 1'b0;
      s16 = src[15:0];
      {a, r, g, b} = src;
      if (dest_fmt == DF_INDEXED8) begin
         if (src_fmt == SF_INDEXED8) begin
            if (src[7:0] != key) begin
               np = {24'd0, src[7:0]};
               we = 1'b1;
            end
         end else begin
            bad = 1'b1;
         end
      end else if (src_fmt == SF_RGB555) begin
         if (s16[15]) begin
            we = 1'b1;
            case (dest_fmt)
               DF_RGB555: np = {16'd0, s16};
               DF_RGB565: np = {16'd0, s16[14:5], 1'b0, s16[4:0]};
               default:   np = {dv[31:24], s16[14:10], 3'd0, s16[9:5], 3'd0, s16[4:0], 3'd0};
            endcase
         end
      end else if (src_fmt == SF_ARGB8888) begin
         if (dest_fmt == DF_XRGB8888) begin
            ga_sat = (glob_alpha > GLOBAL_ALPHA_MAX) ? GLOBAL_ALPHA_MAX : glob_alpha;
            scaled = ga_sat * a;
            a      = scaled[15:8];
         end
         if (a == ALPHA_OPQ) begin
            we = 1'b1;
            case (dest_fmt)
               DF_RGB555: np = {17'd0, r[7:3], g[7:3], b[7:3]};
               DF_RGB565: np = {16'd0, r[7:3], g[7:2], b[7:3]};
               default:   np = src;
            endcase
         end else if (a != ALPHA_CLR) begin
            we = 1'b1;
            case (dest_fmt)
               DF_RGB555: begin
                  dr = blend_channel({dv[14:10], 3'd0}, r, a);
                  dg = blend_channel({dv[9:5], 3'd0}, g, a);
                  db = blend_channel({dv[4:0], 3'd0}, b, a);
                  np = {17'd0, dr[7:3], dg[7:3], db[7:3]};
               end
               DF_RGB565: begin
                  dr = blend_channel({dv[15:11], 3'd0}, r, a);
                  dg = blend_channel({dv[10:5], 2'd0}, g, a);
                  db = blend_channel({dv[4:0], 3'd0}, b, a);
                  np = {16'd0, dr[7:3], dg[7:2], db[7:3]};
               end
               default: begin
                  np = {dv[31:24], blend_channel(dv[23:16], r, a),
                        blend_channel(dv[15:8], g, a), blend_channel(dv[7:0], b, a)};
               end
            endcase
         end
      end else begin
         bad = 1'b1;
      end
      res.new_pixel    = np & dmask;
      res.write_enable = we;
      res.unsupported  = bad;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pixel_writeback_type want;
      logic [1:0]          reg_index;
      if (reset) begin
         dest_fmt   = DF_XRGB8888;
         src_fmt    = SF_ARGB8888;
         key        = COLOR_KEY_RST;
         glob_alpha = GLOBAL_ALPHA_RST;
         expected_writes.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_writes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected writeback beat, expected none, %s %h we=%b unsup=%b",
                        $time, "actual", rsp_mon.new_pixel, rsp_mon.write_enable,
                        rsp_mon.unsupported);
            end else begin
               want = expected_writes.pop_front();
               check_field("new_pixel", want.new_pixel, rsp_mon.new_pixel);
               check_field("write_enable", 32'(want.write_enable), 32'(rsp_mon.write_enable));
               check_field("unsupported", 32'(want.unsupported), 32'(rsp_mon.unsupported));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_writes.push_back(combine_pixel(req_mon.source_pixel, req_mon.dest_pixel));
         if (psel && penable && pwrite && pready) begin
            reg_index = paddr[ADDR_W-1:2];
            case (reg_index)
               REG_DEST_FORMAT:   dest_fmt   = pwdata[1:0];
               REG_SOURCE_FORMAT: src_fmt    = pwdata[1:0];
               REG_COLOR_KEY:     key        = pwdata[7:0];
               REG_GLOBAL_ALPHA:  glob_alpha = pwdata[8:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_writes.size();
   end

endmodule

// File: bench/tb_alpha_key_pixel_combiner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel combiner testbench
// Drives source/destination pixel beats and register writes into the
// combiner. A directed pass covers keying, opacity, copy, skip, blend and the
// unsupported format pairs; random rounds then sweep the format registers,
// key and global alpha with random pixels and random stalls on both sides.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_alpha_key_pixel_combiner_unit;
   import akpc_pkg::*;

   localparam logic [1:0] SF_UNDEFINED   = 2'd3;
   localparam int         HOLD_CYCLES    = 80;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         RANDOM_ROUNDS  = 38;
   localparam int         ROUND_ITEMS    = 50;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int         fail_count;
   int         pending_count;
   int         idle_cycles;
   bit         no_idle;
   bit         hold_rsp_now;
   logic [1:0] cur_src_fmt;
   logic [7:0] cur_key;

   akpc_req_if pixel_req();
   akpc_rsp_if pixel_rsp();

   alpha_key_pixel_combiner_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (pixel_req),
      .rsp_chan (pixel_rsp),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   akpc_writeback_checker writeback_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (pixel_req),
      .rsp_mon       (pixel_rsp),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         pixel_req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pixel_req.valid        <= 1'b1;
      pixel_req.source_pixel <= src;
      pixel_req.dest_pixel   <= dst;
      do @(posedge clock); while (!pixel_req.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      pixel_req.valid <= 1'b0;
      wait (pending_count == 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value, input int width);
      logic [31:0] data;
      data = value;
      if ($urandom_range(0, 3) == 0)
         data = data | ($urandom << width);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_config(input logic [1:0] df, input logic [1:0] sf,
                               input logic [7:0] key, input logic [8:0] ga);
      wait_drained();
      write_csr(REG_DEST_FORMAT, 32'(df), 2);
      write_csr(REG_SOURCE_FORMAT, 32'(sf), 2);
      write_csr(REG_COLOR_KEY, 32'(key), 8);
      write_csr(REG_GLOBAL_ALPHA, 32'(ga), 9);
      cur_src_fmt = sf;
      cur_key     = key;
   endtask

   // response side: random backpressure, plus a long hold when requested
   initial begin
      int stall_left;
      stall_left      = 0;
      pixel_rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_now) begin
            hold_rsp_now = 1'b0;
            pixel_rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_left = 0;
         end
         if (stall_left > 0) begin
            pixel_rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            pixel_rsp.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (pixel_req.valid && pixel_req.ready) ||
          (pixel_rsp.valid && pixel_rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          round;
      int          i;
      int          roll;
      logic [31:0] src;
      logic [31:0] dst;
      logic [1:0]  df;
      logic [1:0]  sf;
      logic [7:0]  key;
      logic [8:0]  ga;

      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      pixel_req.valid        = 1'b0;
      pixel_req.source_pixel = '0;
      pixel_req.dest_pixel   = '0;
      no_idle                = 1'b0;
      hold_rsp_now           = 1'b0;
      idle_cycles            = 0;
      cur_src_fmt            = SF_ARGB8888;
      cur_key                = COLOR_KEY_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 8888 onto 8888: copy, skip, blend up and down, extremes
      apply_config(DF_XRGB8888, SF_ARGB8888, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'hFF12_3456, 32'hA5F0_0F5A);
      send_pixel(32'h00FF_FFFF, 32'h1234_5678);
      send_pixel(32'h80FF_00C8, 32'hCC10_F064);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      // global alpha above 256 saturates, zero global alpha skips
      apply_config(DF_XRGB8888, SF_ARGB8888, 8'hFF, 9'd511);
      send_pixel(32'hFF00_80FF, 32'h7F7F_7F7F);
      apply_config(DF_XRGB8888, SF_ARGB8888, 8'h00, 9'd0);
      send_pixel(32'hFFFF_FFFF, 32'h0102_0304);
      // indexed with color key
      apply_config(DF_INDEXED8, SF_INDEXED8, 8'h5A, GLOBAL_ALPHA_RST);
      send_pixel(32'h0000_005A, 32'hFFFF_FF33);
      send_pixel(32'hFFFF_FF5B, 32'h0000_0011);
      send_pixel(32'hFFFF_FF5A, 32'h0000_00C3);
      // unsupported pairs
      apply_config(DF_INDEXED8, SF_RGB555, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'h0000_FFFF, 32'hDEAD_BEEF);
      apply_config(DF_RGB555, SF_INDEXED8, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'h0000_0077, 32'hDEAD_BEEF);
      apply_config(DF_XRGB8888, SF_INDEXED8, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'h0000_0077, 32'hDEAD_BEEF);
      apply_config(DF_RGB565, SF_UNDEFINED, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'hFFFF_FFFF, 32'hCAFE_F00D);
      // 555 source with opacity bit onto the 555, 565 and 8888 destinations
      apply_config(DF_RGB555, SF_RGB555, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'h0000_FFFF, 32'hFFFF_1234);
      send_pixel(32'hFFFF_7FFF, 32'h0000_ABCD);
      apply_config(DF_RGB565, SF_RGB555, 8'h00, GLOBAL_ALPHA_RST);
      send_pixel(32'h0000_FFFF, 32'h0000_0000);
      apply_config(DF_XRGB8888, SF_RGB555, 8'h00, 9'd1);
      send_pixel(32'h0000_D6B5, 32'hAB00_0000);
      // 8888 source onto 16-bit destinations
      apply_config(DF_RGB555, SF_ARGB8888, 8'h00, 9'd1);
      send_pixel(32'hFFF8_F8F8, 32'h0000_0000);
      send_pixel(32'h80FF_0000, 32'h0000_7FFF);
      send_pixel(32'h00FF_FFFF, 32'h0000_1234);
      apply_config(DF_RGB565, SF_ARGB8888, 8'h00, 9'd0);
      send_pixel(32'hFF00_00FF, 32'h0000_FFFF);
      send_pixel(32'h01FF_FFFF, 32'h0000_0000);
      send_pixel(32'hFE00_0000, 32'hFFFF_FFFF);

      for (round = 0; round < RANDOM_ROUNDS; round++) begin
         df = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 8) begin
            if (df == DF_INDEXED8)
               sf = SF_INDEXED8;
            else
               sf = ($urandom_range(0, 2) == 0) ? SF_RGB555 : SF_ARGB8888;
         end else begin
            sf = 2'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 3) == 0)
            key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else
            key = 8'($urandom);
         case ($urandom_range(0, 7))
            0:       ga = 9'd0;
            1:       ga = 9'd1;
            2:       ga = 9'd255;
            3:       ga = GLOBAL_ALPHA_MAX;
            4:       ga = 9'd257;
            5:       ga = 9'd511;
            default: ga = 9'($urandom_range(0, 511));
         endcase
         apply_config(df, sf, key, ga);
         no_idle = (round % 5 == 2);
         for (i = 0; i < ROUND_ITEMS; i++) begin
            if (round % 9 == 4 && i == 10) begin
               hold_rsp_now = 1'b1;
               no_idle      = 1'b1;
            end
            if (round % 9 == 4 && i == 40)
               no_idle = (round % 5 == 2);
            src  = $urandom;
            dst  = $urandom;
            roll = $urandom_range(0, 99);
            if (cur_src_fmt == SF_INDEXED8 && roll < 30)
               src[7:0] = cur_key;
            if (cur_src_fmt == SF_ARGB8888) begin
               if (roll < 20)
                  src[31:24] = ALPHA_CLR;
               else if (roll < 40)
                  src[31:24] = ALPHA_OPQ;
               else if (roll < 45)
                  src[31:24] = 8'd1;
               else if (roll < 50)
                  src[31:24] = 8'd254;
            end
            if ($urandom_range(0, 9) == 0)
               dst = src;
            send_pixel(src, dst);
         end
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
